### sv/retail_mac_chained_cmac_unit_defines.svh
// Assertion macros for the retail MAC unit
`ifndef RETAIL_MAC_CHAINED_CMAC_UNIT_DEFINES_SVH
`define RETAIL_MAC_CHAINED_CMAC_UNIT_DEFINES_SVH
// Assert a property on the rising clock, off while reset is active
`define RMAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Assert that a condition at one edge implies another at the next edge
`define RMAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### sv/rmac_pkg.sv
// Package for the retail MAC unit: DES tables, round functions and command types
package rmac_pkg;

    typedef logic [5:0] sbox_row_t [64];
    typedef sbox_row_t sbox_all_t [8];

    localparam sbox_all_t SBOX = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}
    };

    typedef logic [6:0] ptab64_t [64];
    typedef logic [6:0] ptab56_t [56];
    typedef logic [6:0] ptab48_t [48];
    typedef logic [6:0] ptab32_t [32];

    localparam ptab64_t PERM_IP = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam ptab64_t PERM_FP = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam ptab48_t PERM_E = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    localparam ptab32_t PERM_P = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam ptab56_t PERM_PC1 = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam ptab48_t PERM_PC2 = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

    // Rotation amount per round: 1 in rounds 0, 1, 8 and 15, else 2
    localparam logic [15:0] SHIFT_ONE = 16'b1000_0001_0000_0011;

    // Configuration register indexes
    localparam logic CFG_KEY_LEFT  = 1'b0;
    localparam logic CFG_KEY_RIGHT = 1'b1;

    // Where the datapath takes the block to cipher from
    typedef enum logic [2:0] {
        SRC_PREV_MAC,
        SRC_CHAIN_XOR,
        SRC_ZERO_XOR,
        SRC_RESULT_XOR,
        SRC_RESULT
    } src_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     load;      // start a DES pass
        src_sel_t src;
        logic     use_right; // key_right instead of key_left
        logic     decrypt;
        logic     round;     // run one round
        logic     chain_wr;  // store pass result as chain value
        logic     mac_wr;    // store pass result as MAC and previous MAC
    } dp_cmd_t;

    function automatic logic [63:0] perm64(input logic [63:0] v, input ptab64_t t);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - t[i]];
        return r;
    endfunction

    function automatic logic [55:0] pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64 - PERM_PC1[i]];
        return r;
    endfunction

    function automatic logic [47:0] pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56 - PERM_PC2[i]];
        return r;
    endfunction

    // DES round function f(R, K)
    function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) x[47-i] = r[32 - PERM_E[i]];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            six = x[42 - 6*i +: 6];
            s[28 - 4*i +: 4] = SBOX[i][{six[5], six[0], six[4:1]}][3:0];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32 - PERM_P[i]];
        return p;
    endfunction

endpackage

### sv/rmac_datapath.sv
// Datapath: chain and MAC registers and one DES round unit with key schedule
module rmac_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  rmac_pkg::dp_cmd_t cmd,
    input  logic [3:0]        round_idx,
    input  logic [63:0]       key_left,
    input  logic [63:0]       key_right,
    input  logic [63:0]       blk,
    output logic [63:0]       mac
);

    logic [63:0] chain_reg, chain_next;
    logic [63:0] prev_reg, prev_next;
    logic [31:0] l_reg, l_next, r_reg, r_next;
    logic [27:0] c_reg, c_next, d_reg, d_next;
    logic [63:0] src, ip, result;
    logic [55:0] cd0;
    logic [27:0] c_rot, d_rot;
    logic        one;
    logic [31:0] f_out;

    // Output of a finished pass: last round applied here, then swap and final permutation
    assign result = rmac_pkg::perm64({l_reg ^ f_out, r_reg}, rmac_pkg::PERM_FP);
    assign mac    = prev_reg;

    always_comb begin
        case (cmd.src)
            rmac_pkg::SRC_PREV_MAC:   src = prev_reg;
            rmac_pkg::SRC_CHAIN_XOR:  src = chain_reg ^ blk;
            rmac_pkg::SRC_ZERO_XOR:   src = blk;
            rmac_pkg::SRC_RESULT_XOR: src = result ^ blk;
            default:                  src = result;
        endcase
    end

    assign ip  = rmac_pkg::perm64(src, rmac_pkg::PERM_IP);
    assign cd0 = rmac_pkg::pc1(cmd.use_right ? key_right : key_left);
    assign one = rmac_pkg::SHIFT_ONE[round_idx];

    // Key schedule: encrypt rotates left before use, decrypt uses then rotates right
    always_comb begin
        if (cmd.decrypt) begin
            c_rot = c_reg;
            d_rot = d_reg;
        end else if (one) begin
            c_rot = {c_reg[26:0], c_reg[27]};
            d_rot = {d_reg[26:0], d_reg[27]};
        end else begin
            c_rot = {c_reg[25:0], c_reg[27:26]};
            d_rot = {d_reg[25:0], d_reg[27:26]};
        end
    end

    assign f_out = rmac_pkg::round_f(r_reg, rmac_pkg::pc2({c_rot, d_rot}));

    always_comb begin
        l_next     = l_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        chain_next = chain_reg;
        prev_next  = prev_reg;
        if (cmd.load) begin
            l_next = ip[63:32];
            r_next = ip[31:0];
            c_next = cd0[55:28];
            d_next = cd0[27:0];
        end else if (cmd.round) begin
            l_next = r_reg;
            r_next = l_reg ^ f_out;
            if (cmd.decrypt) begin
                // decrypt round i uses subkey 15-i; its shift entry is SHIFT_ONE[15-i]
                if (rmac_pkg::SHIFT_ONE[4'd15 - round_idx]) begin
                    c_next = {c_reg[0], c_reg[27:1]};
                    d_next = {d_reg[0], d_reg[27:1]};
                end else begin
                    c_next = {c_reg[1:0], c_reg[27:2]};
                    d_next = {d_reg[1:0], d_reg[27:2]};
                end
            end else begin
                c_next = c_rot;
                d_next = d_rot;
            end
        end
        if (cmd.chain_wr) chain_next = result;
        if (cmd.mac_wr)   prev_next  = result;
    end

    always_ff @(posedge aclk) begin
        l_reg <= l_next;
        r_reg <= r_next;
        c_reg <= c_next;
        d_reg <= d_next;
        if (!aresetn) begin
            chain_reg <= '0;
            prev_reg  <= '0;
        end else begin
            chain_reg <= chain_next;
            prev_reg  <= prev_next;
        end
    end

endmodule

### sv/rmac_ctrl.sv
// Controller: sequences the DES passes of each block
module rmac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_xfer,
    input  logic              last_block,
    input  logic              zero_icv,
    input  logic              out_xfer,
    output logic              in_ready,
    output logic              out_valid,
    output logic [3:0]        round_idx,
    output rmac_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ICV, ST_P1, ST_P2, ST_P3
    } state_t;

    state_t      state_reg;
    logic [3:0]  cnt_reg;
    logic        inside_reg, last_reg, out_reg;
    logic        done;
    logic        mac_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_reg;
    assign round_idx = cnt_reg;
    assign done      = (cnt_reg == 4'd15);
    // output register free now or emptied by this transfer
    assign mac_free  = !out_reg || out_xfer;

    // Command decode
    always_comb begin
        cmd = '0;
        cmd.src = rmac_pkg::SRC_CHAIN_XOR;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = in_xfer;
                if (!inside_reg) begin
                    cmd.src = zero_icv ? rmac_pkg::SRC_ZERO_XOR : rmac_pkg::SRC_PREV_MAC;
                end
            end
            ST_ICV: begin
                cmd.round    = !done;
                cmd.src      = rmac_pkg::SRC_RESULT_XOR;
                cmd.chain_wr = done;
                cmd.load     = done;
            end
            ST_P1: begin
                cmd.round    = !done;
                cmd.src      = rmac_pkg::SRC_RESULT;
                cmd.use_right = 1'b1;
                cmd.chain_wr = done && !last_reg;
                cmd.load     = done && last_reg;
            end
            ST_P2: begin
                cmd.decrypt  = 1'b1;
                cmd.round    = !done;
                cmd.src      = rmac_pkg::SRC_RESULT;
                cmd.load     = done;
            end
            ST_P3: begin
                cmd.round    = !done;
                cmd.mac_wr   = done && mac_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            inside_reg <= 1'b0;
            last_reg   <= 1'b0;
            out_reg    <= 1'b0;
        end else begin
            if (out_xfer) out_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (in_xfer) begin
                    last_reg <= last_block;
                    cnt_reg  <= '0;
                    state_reg <= (!inside_reg && !zero_icv) ? ST_ICV : ST_P1;
                end
                ST_ICV, ST_P2: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (done) state_reg <= (state_reg == ST_ICV) ? ST_P1 : ST_P3;
                end
                ST_P1: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (done) begin
                        inside_reg <= !last_reg;
                        state_reg  <= last_reg ? ST_P2 : ST_IDLE;
                    end
                end
                // final pass waits at its last cycle while the previous MAC is held
                ST_P3: begin
                    if (!done) begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end else if (mac_free) begin
                        cnt_reg   <= '0;
                        out_reg   <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### sv/retail_mac_chained_cmac_unit.sv
// Retail MAC unit (ISO 9797-1 algorithm 3) over pre-padded 64-bit blocks.
// One DES round unit runs one round per cycle: an ordinary block takes the transfer
// cycle plus one pass of rounds (the last round folded into the pass output); a
// first block starting from the previous MAC adds one pass, and a last block adds
// two more passes (decrypt under key_right, encrypt under key_left). The MAC is
// held on m_tdata until taken; blocks of the next message are accepted meanwhile,
// but the next MAC waits in its final cycle until the held one has gone.
`include "retail_mac_chained_cmac_unit_defines.svh"
module retail_mac_chained_cmac_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // block
    input  logic        s_tlast,   // last_block
    input  logic        s_tuser,   // zero_icv
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // mac
);

    logic [63:0]       key_left_reg, key_right_reg, blk_reg;
    logic              in_xfer, out_xfer;
    logic [3:0]        round_idx;
    rmac_pkg::dp_cmd_t cmd;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Key registers and block holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_left_reg  <= '0;
            key_right_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == rmac_pkg::CFG_KEY_LEFT) key_left_reg  <= cfg_wdata;
            else                                     key_right_reg <= cfg_wdata;
        end
        if (in_xfer) blk_reg <= s_tdata;
    end

    rmac_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_xfer    (in_xfer),
        .last_block (s_tlast),
        .zero_icv   (s_tuser),
        .out_xfer   (out_xfer),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .round_idx  (round_idx),
        .cmd        (cmd)
    );

    rmac_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .round_idx (round_idx),
        .key_left  (key_left_reg),
        .key_right (key_right_reg),
        .blk       (in_xfer ? s_tdata : blk_reg),
        .mac       (m_tdata)
    );

    `RMAC_ASSERT(a_busy_not_ready, cmd.round |-> !s_tready, "input ready during a pass")
    `RMAC_ASSERT_NEXT(a_valid_holds, m_tvalid && !m_tready, m_tvalid, "MAC dropped before transfer")
    `RMAC_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, $stable(m_tdata), "MAC changed while waiting")
    `RMAC_ASSERT(a_one_cmd, !(cmd.load && cmd.round), "load and round together")

endmodule

### bench/retail_mac_chained_cmac_unit_tb.sv
// Self-checking bench for the retail MAC unit: DES-based chained MAC predictor and stream checks
`timescale 1ns / 100ps
module retail_mac_chained_cmac_unit_tb;

    typedef struct {
        logic [63:0] block;
        logic        last_block;
        logic        zero_icv;
    } mac_block_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // block
    logic        s_tlast = 1'b0; // last_block
    logic        s_tuser = 1'b0; // zero_icv
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // mac

    retail_mac_chained_cmac_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    // Predictor state
    logic [63:0] key_l = '0, key_r = '0;
    logic [63:0] chain = '0, prev_mac = '0;
    logic        in_msg = 1'b0;

    mac_block_t  pending_blocks[$];
    logic [63:0] expected_macs[$];
    int          failures = 0;
    bit          idle_on = 1'b1;
    bit          hold_send = 1'b0;
    bit          stim_done = 1'b0;
    bit          in_taken = 1'b0;

    // Own DES: tables from the package, logic written here
    function automatic logic [63:0] des_pass(input logic [63:0] key, input logic [63:0] data,
                                             input bit decrypt);
        logic [47:0] sub[16];
        logic [55:0] cd;
        logic [55:0] cdr;
        logic [27:0] c, d;
        logic [63:0] x, y;
        logic [47:0] e;
        logic [31:0] s, p, l, r, t;
        logic [5:0]  six;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64 - rmac_pkg::PERM_PC1[i]];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++) begin
            if (rmac_pkg::SHIFT_ONE[i]) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end else begin
                c = {c[25:0], c[27:26]};
                d = {d[25:0], d[27:26]};
            end
            cdr = {c, d};
            for (int j = 0; j < 48; j++) sub[i][47-j] = cdr[56 - rmac_pkg::PERM_PC2[j]];
        end
        for (int i = 0; i < 64; i++) x[63-i] = data[64 - rmac_pkg::PERM_IP[i]];
        l = x[63:32];
        r = x[31:0];
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 48; j++) e[47-j] = r[32 - rmac_pkg::PERM_E[j]];
            e = e ^ sub[decrypt ? 15 - i : i];
            for (int j = 0; j < 8; j++) begin
                six = e[42 - 6*j +: 6];
                s[28 - 4*j +: 4] = rmac_pkg::SBOX[j][{six[5], six[0], six[4:1]}][3:0];
            end
            for (int j = 0; j < 32; j++) p[31-j] = s[32 - rmac_pkg::PERM_P[j]];
            t = r;
            r = l ^ p;
            l = t;
        end
        x = {r, l};
        for (int i = 0; i < 64; i++) y[63-i] = x[64 - rmac_pkg::PERM_FP[i]];
        return y;
    endfunction

    // Advance the MAC chain by one accepted block
    function automatic void chain_block(input mac_block_t b);
        if (!in_msg) chain = b.zero_icv ? 64'd0 : des_pass(key_l, prev_mac, 1'b0);
        chain = des_pass(key_l, chain ^ b.block, 1'b0);
        if (b.last_block) begin
            chain = des_pass(key_r, chain, 1'b1);
            chain = des_pass(key_l, chain, 1'b0);
            prev_mac = chain;
            expected_macs.push_back(chain);
            in_msg = 1'b0;
        end else begin
            in_msg = 1'b1;
        end
    endfunction

    // Predictor: follow each accepted transfer
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            chain_block('{s_tdata, s_tlast, s_tuser});
            in_taken = 1'b1;
        end
    end

    // Driver
    int send_gap = 0;
    always @(negedge aclk) begin
        if (s_tvalid && !in_taken) begin
            // hold current transfer
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (aresetn && !hold_send && pending_blocks.size() > 0) begin
            mac_block_t b;
            b = pending_blocks.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= b.block;
            s_tlast <= b.last_block;
            s_tuser <= b.zero_icv;
            if (idle_on && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 13);
        end else begin
            s_tvalid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // Sink ready
    int stall = 0;
    always @(negedge aclk) begin
        if (stall > 0) begin
            stall <= stall - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall <= $urandom_range(1, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_macs.size() == 0) begin
                $error("unexpected mac transfer %h", m_tdata);
                failures++;
            end else begin
                logic [63:0] want;
                want = expected_macs.pop_front();
                if (m_tdata !== want) begin
                    $error("mac: expected %h actual %h", want, m_tdata);
                    failures++;
                end
            end
        end
    end

    task automatic write_key(input logic idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == rmac_pkg::CFG_KEY_LEFT) key_l = val;
        else key_r = val;
    endtask

    // Wait until all queued blocks and expected MACs have drained, then settle
    task automatic drain();
        while (pending_blocks.size() > 0 || s_tvalid || expected_macs.size() > 0)
            @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic queue_msg(input int len, input bit zicv);
        for (int i = 0; i < len; i++)
            pending_blocks.push_back('{{$urandom, $urandom}, i == len - 1,
                                       (i == 0) ? zicv : 1'($urandom)});
    endtask

    initial begin
        int n;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero keys, extremes, one-block and multi-block messages
        pending_blocks.push_back('{64'd0, 1'b1, 1'b1});
        pending_blocks.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0});
        drain();
        write_key(rmac_pkg::CFG_KEY_LEFT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_key(rmac_pkg::CFG_KEY_RIGHT, 64'd0);
        pending_blocks.push_back('{64'h0123_4567_89AB_CDEF, 1'b0, 1'b1});
        pending_blocks.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0}); // zero_icv ignored
        pending_blocks.push_back('{64'd0, 1'b1, 1'b1});
        pending_blocks.push_back('{64'hAAAA_5555_AAAA_5555, 1'b0, 1'b0});
        pending_blocks.push_back('{64'h5555_AAAA_5555_AAAA, 1'b1, 1'b1});
        drain();
        write_key(rmac_pkg::CFG_KEY_LEFT, 64'h0123_4567_89AB_CDEF);
        write_key(rmac_pkg::CFG_KEY_RIGHT, 64'hFEDC_BA98_7654_3210);
        pending_blocks.push_back('{64'd0, 1'b1, 1'b0});
        pending_blocks.push_back('{64'd0, 1'b1, 1'b0});
        pending_blocks.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1});
        drain();
        // Key change mid message, between blocks
        queue_msg(1, 1'b1);
        pending_blocks.push_back('{{$urandom, $urandom}, 1'b0, 1'b0});
        drain();
        write_key(rmac_pkg::CFG_KEY_RIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
        pending_blocks.push_back('{{$urandom, $urandom}, 1'b1, 1'b0});
        drain();

        // Random phases with new keys
        for (int ph = 0; ph < 6; ph++) begin
            write_key(rmac_pkg::CFG_KEY_LEFT, {$urandom, $urandom});
            write_key(rmac_pkg::CFG_KEY_RIGHT, {$urandom, $urandom});
            if (ph == 5) idle_on = 1'b0;
            n = 0;
            while (n < 210) begin
                int len;
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 6);
                queue_msg(len, 1'($urandom));
                n += len;
                if (ph == 2 && n > 100 && n < 110) begin
                    // sender stops and waits until every expected MAC has been taken
                    while (pending_blocks.size() > 0 || s_tvalid) @(negedge aclk);
                    hold_send = 1'b1;
                    while (expected_macs.size() > 0 || in_msg) @(negedge aclk);
                    hold_send = 1'b0;
                end
            end
            drain();
        end
        stim_done = 1'b1;
    end

    // Final verdict
    initial begin
        wait (stim_done);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Timeout
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/rmac_pkg.sv
sv/rmac_datapath.sv
sv/rmac_ctrl.sv
sv/retail_mac_chained_cmac_unit.sv
bench/retail_mac_chained_cmac_unit_tb.sv
